// File: rtl/core/pfact_pkg.sv
// shared types and constants for the prime factorization block
package pfact_pkg;

   localparam int VALUE_BITS_DEF = 31;

   // first odd trial divisor and its square
   localparam int FIRST_ODD = 3;
   localparam int FIRST_SQ  = 9;
   localparam int SMALLEST_PRIME = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TEST,
      ST_STRIP,
      ST_CHECK,
      ST_DIV,
      ST_DECIDE,
      ST_FINAL,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic load;
      logic emit_none;
      logic push_two;
      logic div_start;
      logic div_step;
      logic take_quot;
      logic next_div;
      logic push_rem;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic rem_lt2;
      logic rem_even;
      logic sq_gt_rem;
      logic div_last;
      logic part_zero;
   } status_type;

endpackage

// File: rtl/core/pfact_ctrl.sv
// controller state machine for the prime factorization block
module pfact_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pfact_pkg::status_type st,
   output pfact_pkg::cmd_type   cmd
);

   pfact_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfact_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         pfact_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = pfact_pkg::ST_TEST;
            end
         end
         pfact_pkg::ST_TEST: begin
            if (st.rem_lt2) begin
               cmd.emit_none = 1'b1;
               state_in      = pfact_pkg::ST_IDLE;
            end else begin
               state_in = pfact_pkg::ST_STRIP;
            end
         end
         pfact_pkg::ST_STRIP: begin
            if (st.rem_even) begin
               cmd.push_two = 1'b1;
            end else begin
               state_in = pfact_pkg::ST_CHECK;
            end
         end
         pfact_pkg::ST_CHECK: begin
            if (st.sq_gt_rem) begin
               state_in = pfact_pkg::ST_FINAL;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = pfact_pkg::ST_DIV;
            end
         end
         pfact_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = pfact_pkg::ST_DECIDE;
            end
         end
         pfact_pkg::ST_DECIDE: begin
            // divisible: keep the same divisor and try it again
            if (st.part_zero) begin
               cmd.take_quot = 1'b1;
            end else begin
               cmd.next_div = 1'b1;
            end
            state_in = pfact_pkg::ST_CHECK;
         end
         pfact_pkg::ST_FINAL: begin
            if (!st.rem_lt2) begin
               cmd.push_rem = 1'b1;
            end
            state_in = pfact_pkg::ST_LAST;
         end
         pfact_pkg::ST_LAST: begin
            cmd.flush = 1'b1;
            state_in  = pfact_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfact_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != pfact_pkg::ST_IDLE);

endmodule

// File: rtl/core/pfact_dp.sv
// datapath: remainder, trial divisor, bit-serial divider and result registers
module pfact_dp #(
   parameter int VALUE_BITS = pfact_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  pfact_pkg::cmd_type     cmd,
   output pfact_pkg::status_type  st,
   output logic                   rsp_strobe,
   output logic [VALUE_BITS-1:0]  rsp_factor,
   output logic                   rsp_last,
   output logic                   rsp_none
);

   localparam int W     = VALUE_BITS;
   localparam int SQ_W  = VALUE_BITS + 2;
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     div_ff, div_in;
   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     part_ff, part_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]     pend_ff, pend_in;
   logic             pend_vld_ff, pend_vld_in;
   logic             out_vld_ff, out_vld_in;
   logic [W-1:0]     out_factor_ff, out_factor_in;
   logic             out_last_ff, out_last_in;
   logic             out_none_ff, out_none_in;

   logic [W:0]       trial;
   logic [W:0]       diff;
   logic             push;
   logic [W-1:0]     push_val;

   // one restoring division step
   assign trial = {part_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};

   assign push = cmd.push_two | cmd.take_quot | cmd.push_rem;

   always_comb begin
      priority if (cmd.push_two) begin
         push_val = W'(pfact_pkg::SMALLEST_PRIME);
      end else if (cmd.take_quot) begin
         push_val = div_ff;
      end else begin
         push_val = rem_ff;
      end
   end

   always_comb begin
      rem_in        = rem_ff;
      div_in        = div_ff;
      sq_in         = sq_ff;
      quo_in        = quo_ff;
      part_in       = part_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_vld_in   = pend_vld_ff;
      out_vld_in    = 1'b0;
      out_factor_in = out_factor_ff;
      out_last_in   = out_last_ff;
      out_none_in   = out_none_ff;

      if (cmd.load) begin
         rem_in      = req_value;
         div_in      = W'(pfact_pkg::FIRST_ODD);
         sq_in       = SQ_W'(pfact_pkg::FIRST_SQ);
         pend_vld_in = 1'b0;
      end
      if (cmd.push_two) begin
         rem_in = rem_ff >> 1;
      end
      if (cmd.div_start) begin
         quo_in  = rem_ff;
         part_in = '0;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         if (diff[W]) begin
            part_in = trial[W-1:0];
            quo_in  = {quo_ff[W-2:0], 1'b0};
         end else begin
            part_in = diff[W-1:0];
            quo_in  = {quo_ff[W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.take_quot) begin
         rem_in = quo_ff;
      end
      if (cmd.next_div) begin
         // (d+2)^2 = d^2 + 4d + 4
         div_in = div_ff + W'(2);
         sq_in  = sq_ff + {div_ff, 2'b00} + SQ_W'(4);
      end

      // a new factor releases the held one, which is then known not to be last
      if (push) begin
         if (pend_vld_ff) begin
            out_vld_in    = 1'b1;
            out_factor_in = pend_ff;
            out_last_in   = 1'b0;
            out_none_in   = 1'b0;
         end
         pend_in     = push_val;
         pend_vld_in = 1'b1;
      end
      if (cmd.flush) begin
         out_vld_in    = 1'b1;
         out_factor_in = pend_ff;
         out_last_in   = 1'b1;
         out_none_in   = 1'b0;
         pend_vld_in   = 1'b0;
      end
      if (cmd.emit_none) begin
         out_vld_in    = 1'b1;
         out_factor_in = '0;
         out_last_in   = 1'b1;
         out_none_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      sq_ff         <= sq_in;
      quo_ff        <= quo_in;
      part_ff       <= part_in;
      cnt_ff        <= cnt_in;
      pend_ff       <= pend_in;
      out_factor_ff <= out_factor_in;
      out_last_ff   <= out_last_in;
      out_none_ff   <= out_none_in;
   end

   assign st.rem_lt2   = (rem_ff[W-1:1] == '0);
   assign st.rem_even  = ~rem_ff[0];
   assign st.sq_gt_rem = (sq_ff > {2'b00, rem_ff});
   assign st.div_last  = (cnt_ff == CNT_W'(W - 1));
   assign st.part_zero = (part_ff == '0);

   assign rsp_strobe = out_vld_ff;
   assign rsp_factor = out_factor_ff;
   assign rsp_last   = out_last_ff;
   assign rsp_none   = out_none_ff;

endmodule

// File: rtl/core/prime_factorization_top.sv
// prime factorization by trial division: one value in, its prime factors out
// each trial division passes the states CHECK, DIV and DECIDE, with DIV run by the
// one-bit-a-cycle remainder unit; a 31-bit prime tries about 23000 divisors,
// and powers of two are stripped one factor of 2 at a time without dividing
// one word at a time: busy falls in the cycle that carries the last factor strobe
// reset clears the controller and the result strobe; results cannot be stalled
module prime_factorization_top #(
   parameter int VALUE_BITS = pfact_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_strobe,
   output logic [VALUE_BITS-1:0] rsp_factor,
   output logic                  rsp_last,
   output logic                  rsp_none
);

   pfact_pkg::cmd_type    cmd;
   pfact_pkg::status_type st;

   pfact_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .st    (st),
      .cmd   (cmd)
   );

   pfact_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .cmd        (cmd),
      .st         (st),
      .rsp_strobe (rsp_strobe),
      .rsp_factor (rsp_factor),
      .rsp_last   (rsp_last),
      .rsp_none   (rsp_none)
   );

endmodule
